FILE: rtl/core/gha_pkg.sv
package gha_pkg;

  localparam int SLOTS    = 1024;
  localparam int IDX_W    = $clog2(SLOTS);
  localparam int CNT_W    = $clog2(SLOTS + 1);
  localparam int GEN_BITS = 12;
  localparam int ENT_W    = GEN_BITS + 1;

  typedef logic [IDX_W-1:0]    idx_t;
  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [GEN_BITS-1:0] gen_t;
  typedef logic [ENT_W-1:0]    ent_t;

  localparam gen_t GEN_MAX   = {GEN_BITS{1'b1}};
  localparam idx_t IDX_LAST  = IDX_W'(SLOTS - 1);
  localparam cnt_t CNT_SLOTS = CNT_W'(SLOTS);

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_CHECK   = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_STALE     = 2'd1,
    ST_FULL      = 2'd2,
    ST_EXHAUSTED = 2'd3
  } status_t;

  // generation table port: entry is {live, generation}
  typedef struct packed {
    logic re;
    idx_t raddr;
    logic we;
    idx_t waddr;
    ent_t wdata;
  } tbl_req_t;

  typedef struct packed {
    logic re;
    idx_t raddr;
    logic we;
    idx_t waddr;
    idx_t wdata;
  } fifo_req_t;

endpackage

FILE: rtl/core/gha_req_if.sv
interface gha_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  gha_pkg::idx_t      handle_index;
  gha_pkg::gen_t      handle_generation;

  modport source (output valid, output op, output handle_index,
                  output handle_generation, input ready);
  modport sink (input valid, input op, input handle_index,
                input handle_generation, output ready);
endinterface

FILE: rtl/core/gha_rsp_if.sv
interface gha_rsp_if;
  logic               valid;
  logic               ready;
  gha_pkg::idx_t      out_index;
  gha_pkg::gen_t      out_generation;
  logic [1:0]         status;

  modport source (output valid, output out_index, output out_generation,
                  output status, input ready);
  modport sink (input valid, input out_index, input out_generation,
                input status, output ready);
endinterface

FILE: rtl/core/gha_ram.sv
module gha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/gha_ctrl.sv
module gha_ctrl (
  input  logic                clk,
  input  logic                rst,
  gha_req_if.sink             req,
  gha_rsp_if.source           rsp,
  output gha_pkg::tbl_req_t   tbl,
  input  gha_pkg::ent_t       tbl_rdata,
  output gha_pkg::fifo_req_t  fifo,
  input  gha_pkg::idx_t       fifo_rdata
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_FIFO,
    S_DONE
  } state_t;

  state_t         state;
  logic [1:0]     op_r;
  gha_pkg::idx_t  idx_r;
  gha_pkg::gen_t  gen_r;
  logic           in_range;
  gha_pkg::cnt_t  issued;
  gha_pkg::cnt_t  count;
  gha_pkg::idx_t  head;
  gha_pkg::idx_t  tail;

  logic               accept;
  logic               req_in_range;
  logic               fire;
  logic               ent_live;
  gha_pkg::gen_t      ent_gen;
  logic               handle_ok;
  gha_pkg::idx_t      res_idx;
  gha_pkg::gen_t      res_gen;
  gha_pkg::status_t   res_st;
  logic               do_pop;
  logic               do_issue;
  logic               do_push;

  assign req.ready    = (state == S_IDLE);
  assign accept       = req.valid && req.ready;
  assign req_in_range = {1'b0, req.handle_index} < issued;
  assign fire         = (state == S_DONE) && (!rsp.valid || rsp.ready);

  assign ent_live  = tbl_rdata[gha_pkg::GEN_BITS];
  assign ent_gen   = tbl_rdata[gha_pkg::GEN_BITS-1:0];
  assign handle_ok = in_range && ent_live && (ent_gen == gen_r);

  // result and write-back for the transaction held in S_DONE
  always_comb begin
    res_idx  = idx_r;
    res_gen  = gen_r;
    res_st   = gha_pkg::ST_STALE;
    do_pop   = 1'b0;
    do_issue = 1'b0;
    do_push  = 1'b0;
    unique case (op_r)
      gha_pkg::OP_ALLOC: begin
        if (count != '0) begin
          res_gen = ent_gen;
          res_st  = gha_pkg::ST_OK;
          do_pop  = 1'b1;
        end else if (issued < gha_pkg::CNT_SLOTS) begin
          res_idx  = issued[gha_pkg::IDX_W-1:0];
          res_gen  = '0;
          res_st   = gha_pkg::ST_OK;
          do_issue = 1'b1;
        end else begin
          res_idx = '0;
          res_gen = '0;
          res_st  = gha_pkg::ST_FULL;
        end
      end
      gha_pkg::OP_RELEASE: begin
        if (!handle_ok) begin
          res_st = gha_pkg::ST_STALE;
        end else if (ent_gen == gha_pkg::GEN_MAX) begin
          res_st = gha_pkg::ST_EXHAUSTED;
        end else begin
          res_st  = gha_pkg::ST_OK;
          do_push = 1'b1;
        end
      end
      gha_pkg::OP_CHECK: begin
        res_st = handle_ok ? gha_pkg::ST_OK : gha_pkg::ST_STALE;
      end
      default: begin
        res_st = gha_pkg::ST_STALE;
      end
    endcase
  end

  always_comb begin
    tbl  = '0;
    fifo = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (req.op == gha_pkg::OP_ALLOC) begin
            fifo.re    = (count != '0);
            fifo.raddr = head;
          end else if (req.op == gha_pkg::OP_RELEASE || req.op == gha_pkg::OP_CHECK) begin
            tbl.re    = req_in_range;
            tbl.raddr = req.handle_index;
          end
        end
      end
      S_FIFO: begin
        tbl.re    = 1'b1;
        tbl.raddr = fifo_rdata;
      end
      S_DONE: begin
        if (fire) begin
          tbl.we     = do_pop || do_issue || do_push;
          tbl.waddr  = res_idx;
          tbl.wdata  = do_push ? {1'b0, ent_gen + gha_pkg::gen_t'(1)}
                               : {1'b1, res_gen};
          fifo.we    = do_push;
          fifo.waddr = tail;
          fifo.wdata = idx_r;
        end
      end
      default: begin
        tbl  = '0;
        fifo = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      issued    <= '0;
      count     <= '0;
      head      <= '0;
      tail      <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (fire) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op_r     <= req.op;
            idx_r    <= req.handle_index;
            gen_r    <= req.handle_generation;
            in_range <= req_in_range;
            if (req.op == gha_pkg::OP_ALLOC && count != '0) begin
              state <= S_FIFO;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_FIFO: begin
          idx_r <= fifo_rdata;
          state <= S_DONE;
        end
        S_DONE: begin
          if (fire) begin
            rsp.out_index      <= res_idx;
            rsp.out_generation <= res_gen;
            rsp.status         <= res_st;
            if (do_pop) begin
              head  <= (head == gha_pkg::IDX_LAST) ? '0 : head + 1'b1;
              count <= count - 1'b1;
            end
            if (do_push) begin
              tail  <= (tail == gha_pkg::IDX_LAST) ? '0 : tail + 1'b1;
              count <= count + 1'b1;
            end
            if (do_issue) begin
              issued <= issued + 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/core/generational_handle_allocator_core.sv
// Generational handle allocator: allocate returns the oldest released slot
// (FIFO order) at its current generation, or a fresh slot at generation 0
// until 1024 slots are out; release checks the handle, bumps the slot's
// generation and queues the slot for reuse unless the generation is at its
// maximum; check reports whether a handle is live. The result of a
// transaction is loaded into the output register from S_DONE, which an
// allocate that reuses a released slot reaches through S_FIFO, since the
// free FIFO and the generation table are memories with a registered read
// that are read one after the other. The input is ready again in the cycle
// after the result is loaded. One transaction is in flight at a time; a new
// one is accepted while the previous result still waits on the output, and
// the next result waits for the output to drain. After reset the block is
// ready at once, with no clearing pass.
module generational_handle_allocator_core (
  input  logic       clk,
  input  logic       rst,
  gha_req_if.sink    req,
  gha_rsp_if.source  rsp
);

  gha_pkg::tbl_req_t   tbl;
  gha_pkg::ent_t       tbl_rdata;
  gha_pkg::fifo_req_t  fifo;
  gha_pkg::idx_t       fifo_rdata;

  gha_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .rsp        (rsp),
    .tbl        (tbl),
    .tbl_rdata  (tbl_rdata),
    .fifo       (fifo),
    .fifo_rdata (fifo_rdata)
  );

  // entry is {live, generation}
  gha_ram #(
    .WIDTH (gha_pkg::ENT_W),
    .DEPTH (gha_pkg::SLOTS)
  ) u_gen_table (
    .clk   (clk),
    .re    (tbl.re),
    .raddr (tbl.raddr),
    .rdata (tbl_rdata),
    .we    (tbl.we),
    .waddr (tbl.waddr),
    .wdata (tbl.wdata)
  );

  gha_ram #(
    .WIDTH (gha_pkg::IDX_W),
    .DEPTH (gha_pkg::SLOTS)
  ) u_free_fifo (
    .clk   (clk),
    .re    (fifo.re),
    .raddr (fifo.raddr),
    .rdata (fifo_rdata),
    .we    (fifo.we),
    .waddr (fifo.waddr),
    .wdata (fifo.wdata)
  );

`ifndef SYNTH
  // table reads and write-backs never share a cycle, so no forwarding is needed
  a_tbl_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(tbl.re && tbl.we))
    else $error("table read and write in the same cycle");

  a_fifo_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(fifo.re && fifo.we))
    else $error("free fifo read and write in the same cycle");

  a_write_not_idle: assert property (@(posedge clk) disable iff (rst)
    (tbl.we || fifo.we) |-> !req.ready)
    else $error("memory write while accepting transactions");

  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(!req.ready))
    else $error("result loaded without a transaction in progress");
`endif

endmodule
